### hw/rtl/btlv_pkg.sv
// ----------------------------------------------------------------------------
// btlv_pkg: shared types and constants of the BER-TLV stream parser
// Sizes of the nesting stack, tag and length fields, word layouts and codes.
// ----------------------------------------------------------------------------
package btlv_pkg;

	localparam int MAX_DEPTH        = 8;
	localparam int MAX_TAG_BYTES    = 4;
	localparam int MAX_LENGTH_BYTES = 4;

	localparam int DEPTH_W  = $clog2(MAX_DEPTH + 1);
	localparam int CLOSED_W = $clog2(MAX_DEPTH + 2);
	localparam int TCNT_W   = $clog2(MAX_TAG_BYTES + 1);
	localparam int LBL_W    = $clog2(MAX_LENGTH_BYTES + 1);
	localparam int TAG_W    = 32;
	localparam int LEN_W    = 32;
	localparam int DEPTH_OUT_W  = 4;
	localparam int CLOSED_OUT_W = 4;

	localparam logic [7:0] CONSTRUCTED_MASK = 8'b0010_0000;
	localparam logic [7:0] TAG_LOW_MASK     = 8'b0001_1111;
	localparam logic [7:0] MORE_MASK        = 8'b1000_0000;
	localparam logic [7:0] LEN_INDEFINITE   = 8'h80;

	typedef enum logic [1:0] {
		ROLE_TAG     = 2'd0,
		ROLE_LENGTH  = 2'd1,
		ROLE_VALUE   = 2'd2,
		ROLE_IGNORED = 2'd3
	} role_t;

	typedef enum logic [2:0] {
		ERR_NONE      = 3'd0,
		ERR_TAG_LONG  = 3'd1,
		ERR_LEN_FORM  = 3'd2,
		ERR_OVERRUN   = 3'd3,
		ERR_TRUNCATED = 3'd4
	} err_t;

	typedef struct packed {
		role_t                    byte_role;
		logic [DEPTH_OUT_W-1:0]   depth;
		logic [TAG_W-1:0]         tag_value;
		logic                     is_constructed;
		logic [LEN_W-1:0]         value_length;
		logic                     header_done;
		logic [CLOSED_OUT_W-1:0]  closed_count;
		err_t                     error_code;
	} out_word_t;

	typedef struct packed {
		logic             advance;
		logic             push;
		logic [LEN_W-1:0] push_value;
	} cell_ctrl_t;

	typedef struct packed {
		logic [LEN_W-1:0]   top;
		logic [DEPTH_W-1:0] zeros;
	} chain_t;

endpackage

### hw/rtl/btlv_if.sv
// ----------------------------------------------------------------------------
// btlv_if: stream channels of the BER-TLV stream parser
// Input byte channel and per-byte report channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface btlv_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, data_byte, last_byte, input ready);
	modport sink (input valid, data_byte, last_byte, output ready);
endinterface

interface btlv_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  byte_role;
	logic [3:0]  depth;
	logic [31:0] tag_value;
	logic        is_constructed;
	logic [31:0] value_length;
	logic        header_done;
	logic [3:0]  closed_count;
	logic [2:0]  error_code;

	modport source (output valid, byte_role, depth, tag_value, is_constructed,
		value_length, header_done, closed_count, error_code, input ready);
	modport sink (input valid, byte_role, depth, tag_value, is_constructed,
		value_length, header_done, closed_count, error_code, output ready);
endinterface

### hw/rtl/btlv_cell.sv
// ----------------------------------------------------------------------------
// btlv_cell: one level of the nesting stack
// Holds the bytes left in one open constructed element, counts down with
// each word and passes the top count and the number of exhausted levels on.
// ----------------------------------------------------------------------------
module btlv_cell (
	input  logic                clk,
	input  btlv_pkg::cell_ctrl_t ctrl,
	input  logic                active,
	input  logic                push_here,
	input  btlv_pkg::chain_t     chain_in,
	output btlv_pkg::chain_t     chain_out
);
	import btlv_pkg::*;

	logic [LEN_W-1:0] rem_q;
	logic [LEN_W-1:0] rem_dec;

	assign rem_dec = rem_q - LEN_W'(1);

	always_comb begin
		chain_out = chain_in;
		if (active) begin
			chain_out.top = rem_dec;
			if (rem_dec == '0) begin
				chain_out.zeros = chain_in.zeros + DEPTH_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.push && push_here) begin
			rem_q <= ctrl.push_value;
		end else if (ctrl.advance && active) begin
			rem_q <= rem_dec;
		end
	end

endmodule

### hw/rtl/btlv_skid.sv
// ----------------------------------------------------------------------------
// btlv_skid: two-entry output buffer of the BER-TLV stream parser
// Registers the report word and keeps one spare entry so the parser can take
// a byte in the cycle the sink stalls.
// ----------------------------------------------------------------------------
module btlv_skid (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_valid,
	output logic                wr_ready,
	input  btlv_pkg::out_word_t wr_word,
	btlv_out_if.source          res
);
	import btlv_pkg::*;

	logic      main_v_q;
	logic      skid_v_q;
	out_word_t main_q;
	out_word_t skid_q;
	logic      wr;
	logic      load_main;

	assign wr_ready  = !skid_v_q;
	assign wr        = wr_valid && wr_ready;
	assign load_main = !main_v_q || res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (load_main) begin
			if (skid_v_q) begin
				main_v_q <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				main_v_q <= wr;
			end
		end else if (wr) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_main) begin
			main_q <= skid_v_q ? skid_q : wr_word;
		end else if (wr) begin
			skid_q <= wr_word;
		end
	end

	assign res.valid          = main_v_q;
	assign res.byte_role      = main_q.byte_role;
	assign res.depth          = main_q.depth;
	assign res.tag_value      = main_q.tag_value;
	assign res.is_constructed = main_q.is_constructed;
	assign res.value_length   = main_q.value_length;
	assign res.header_done    = main_q.header_done;
	assign res.closed_count   = main_q.closed_count;
	assign res.error_code     = main_q.error_code;

endmodule

### hw/rtl/ber_tlv_stream_parser.sv
// ----------------------------------------------------------------------------
// ber_tlv_stream_parser: byte-serial BER-TLV parser
// A two-entry output buffer registers the report word of each byte taken.
// Throughput: one byte per cycle unless the output buffer is full; the state
// update of each byte completes in the cycle it is taken, the nesting stack
// is a row of down-counting cells; a byte is still taken when the sink stalls.
// Reset (async, active low) clears the parser state and the sticky error.
// ----------------------------------------------------------------------------
module ber_tlv_stream_parser (
	input  logic      clk,
	input  logic      arst_n,
	btlv_in_if.sink   msg,
	btlv_out_if.source res
);
	import btlv_pkg::*;

	typedef enum logic [3:0] {
		PH_TAG_FIRST = 4'b0001,
		PH_TAG_MORE  = 4'b0010,
		PH_LENGTH    = 4'b0100,
		PH_VALUE     = 4'b1000
	} phase_t;

	phase_t             phase_q, phase_n;
	logic [TAG_W-1:0]   tag_q, tag_n;
	logic [TCNT_W-1:0]  tcnt_q, tcnt_n;
	logic [LEN_W-1:0]   len_q, len_n;
	logic [LBL_W-1:0]   lbl_q, lbl_n;
	logic               cflag_q, cflag_n;
	logic [LEN_W-1:0]   vleft_q, vleft_n;
	logic [DEPTH_W-1:0] depth_q, depth_n;
	err_t               sticky_q;

	role_t               role;
	err_t                err;
	logic                hdr;
	logic                close_one;
	logic                do_push;
	logic                pop;
	logic [CLOSED_W-1:0] closed;
	logic [7:0]          b;
	logic                take;
	logic                wr_ready;
	logic                live;
	out_word_t           word;
	cell_ctrl_t          cell_ctrl;
	chain_t              chain [MAX_DEPTH+1];
	logic [LEN_W-1:0]    parent_left;
	logic [DEPTH_W-1:0]  zcnt;

	assign b    = msg.data_byte;
	assign take = msg.valid && wr_ready;
	assign live = (sticky_q == ERR_NONE);
	assign msg.ready = wr_ready;

	// nesting stack
	assign chain[0] = '0;
	assign parent_left = chain[MAX_DEPTH].top;
	assign zcnt        = chain[MAX_DEPTH].zeros;

	assign cell_ctrl.advance    = take && live;
	assign cell_ctrl.push       = take && live && do_push && (err == ERR_NONE);
	assign cell_ctrl.push_value = len_n;

	for (genvar i = 0; i < MAX_DEPTH; i++) begin : g_cell
		btlv_cell u_cell (
			.clk       (clk),
			.ctrl      (cell_ctrl),
			.active    (depth_q > DEPTH_W'(i)),
			.push_here (depth_q == DEPTH_W'(i)),
			.chain_in  (chain[i]),
			.chain_out (chain[i+1])
		);
	end

	always_comb begin
		role      = ROLE_TAG;
		hdr       = 1'b0;
		err       = ERR_NONE;
		close_one = 1'b0;
		do_push   = 1'b0;
		phase_n   = phase_q;
		tag_n     = tag_q;
		tcnt_n    = tcnt_q;
		len_n     = len_q;
		lbl_n     = lbl_q;
		cflag_n   = cflag_q;
		vleft_n   = vleft_q;

		case (phase_q)
			PH_TAG_FIRST: begin
				role    = ROLE_TAG;
				cflag_n = |(b & CONSTRUCTED_MASK);
				tag_n   = TAG_W'(b);
				tcnt_n  = TCNT_W'(1);
				len_n   = '0;
				lbl_n   = '0;
				phase_n = ((b & TAG_LOW_MASK) == TAG_LOW_MASK) ? PH_TAG_MORE : PH_LENGTH;
			end
			PH_TAG_MORE: begin
				role   = ROLE_TAG;
				tag_n  = {tag_q[TAG_W-9:0], b};
				tcnt_n = tcnt_q + TCNT_W'(1);
				if (|(b & MORE_MASK)) begin
					if (tcnt_n >= TCNT_W'(MAX_TAG_BYTES)) begin
						err = ERR_TAG_LONG;
					end
				end else begin
					phase_n = PH_LENGTH;
				end
			end
			PH_LENGTH: begin
				role = ROLE_LENGTH;
				if (lbl_q == '0) begin
					if (!(|(b & MORE_MASK))) begin
						len_n = LEN_W'(b);
						hdr   = 1'b1;
					end else if (b == LEN_INDEFINITE ||
						{1'b0, b[6:0]} > 8'(MAX_LENGTH_BYTES)) begin
						err = ERR_LEN_FORM;
					end else begin
						lbl_n = LBL_W'(b[6:0]);
						len_n = '0;
					end
				end else if (len_q[LEN_W-1 -: 8] != 8'd0) begin
					err = ERR_LEN_FORM;
				end else begin
					len_n = {len_q[LEN_W-9:0], b};
					lbl_n = lbl_q - LBL_W'(1);
					hdr   = (lbl_n == '0);
				end
			end
			PH_VALUE: begin
				role    = ROLE_VALUE;
				vleft_n = vleft_q - LEN_W'(1);
				if (vleft_n == '0) begin
					close_one = 1'b1;
					phase_n   = PH_TAG_FIRST;
				end
			end
			default: begin
				role    = ROLE_IGNORED;
				phase_n = PH_TAG_FIRST;
			end
		endcase

		if (err == ERR_NONE && hdr) begin
			if (depth_q != '0 && len_n > parent_left) begin
				err = ERR_OVERRUN;
			end else if (len_n == '0) begin
				close_one = 1'b1;
				phase_n   = PH_TAG_FIRST;
			end else if (cflag_n && depth_q < DEPTH_W'(MAX_DEPTH)) begin
				do_push = 1'b1;
				phase_n = PH_TAG_FIRST;
			end else begin
				vleft_n = len_n;
				phase_n = PH_VALUE;
			end
		end else if (err == ERR_NONE && role != ROLE_VALUE && depth_q != '0 &&
			parent_left == '0) begin
			err = ERR_OVERRUN;
		end

		pop = (err == ERR_NONE) && (phase_n == PH_TAG_FIRST) && !do_push;

		if (do_push) begin
			depth_n = depth_q + DEPTH_W'(1);
		end else if (pop) begin
			depth_n = depth_q - zcnt;
		end else begin
			depth_n = depth_q;
		end

		closed = pop ? CLOSED_W'(zcnt) + CLOSED_W'(close_one) : '0;

		if (err == ERR_NONE && msg.last_byte &&
			!(phase_n == PH_TAG_FIRST && depth_n == '0)) begin
			err = ERR_TRUNCATED;
		end
	end

	always_comb begin
		if (!live) begin
			word.byte_role      = ROLE_IGNORED;
			word.depth          = DEPTH_OUT_W'(depth_q);
			word.tag_value      = tag_q;
			word.is_constructed = cflag_q;
			word.value_length   = len_q;
			word.header_done    = 1'b0;
			word.closed_count   = '0;
			word.error_code     = sticky_q;
		end else begin
			word.byte_role      = role;
			word.depth          = DEPTH_OUT_W'(depth_q);
			word.tag_value      = tag_n;
			word.is_constructed = cflag_n;
			word.value_length   = len_n;
			word.header_done    = hdr && (err == ERR_NONE);
			word.closed_count   = (err == ERR_NONE) ? CLOSED_OUT_W'(closed) : '0;
			word.error_code     = err;
		end
	end

	// a truncated message still keeps the depth reached by its last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_TAG_FIRST;
			tag_q    <= '0;
			tcnt_q   <= '0;
			len_q    <= '0;
			lbl_q    <= '0;
			cflag_q  <= 1'b0;
			depth_q  <= '0;
			sticky_q <= ERR_NONE;
		end else if (take && live) begin
			phase_q  <= phase_n;
			tag_q    <= tag_n;
			tcnt_q   <= tcnt_n;
			len_q    <= len_n;
			lbl_q    <= lbl_n;
			cflag_q  <= cflag_n;
			sticky_q <= err;
			depth_q  <= depth_n;
		end
	end

	always_ff @(posedge clk) begin
		if (take && live) begin
			vleft_q <= vleft_n;
		end
	end

	btlv_skid u_skid (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (msg.valid),
		.wr_ready (wr_ready),
		.wr_word  (word),
		.res      (res)
	);

endmodule

### hw/rtl/btlv_chk.sv
// ----------------------------------------------------------------------------
// btlv_chk: port checker of the BER-TLV stream parser
// Watches the report channel for sticky error behavior and consistent flags.
// ----------------------------------------------------------------------------
module btlv_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        res_valid,
	input logic        res_ready,
	input logic [1:0]  byte_role,
	input logic [3:0]  depth,
	input logic [31:0] tag_value,
	input logic [31:0] value_length,
	input logic        header_done,
	input logic [3:0]  closed_count,
	input logic [2:0]  error_code
);
	import btlv_pkg::*;

	logic       err_seen_q;
	logic [2:0] err_code_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			err_seen_q <= 1'b0;
			err_code_q <= '0;
		end else if (res_valid && res_ready && !err_seen_q && error_code != ERR_NONE) begin
			err_seen_q <= 1'b1;
			err_code_q <= error_code;
		end
	end

	a_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && err_seen_q) |-> (byte_role == ROLE_IGNORED && error_code == err_code_q))
		else $error("report after an error is not ignored with the sticky code");

	a_err_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && error_code != ERR_NONE) |-> (!header_done && closed_count == 4'd0))
		else $error("error word shows header end or closings");

	a_hdr_role: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && header_done) |-> (byte_role == ROLE_LENGTH))
		else $error("header end on a byte that is not a length byte");

	a_ignored_err: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && byte_role == ROLE_IGNORED) |-> (error_code != ERR_NONE))
		else $error("ignored byte without an error code");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_ready) |=> (res_valid && $stable(depth) && $stable(tag_value) &&
			$stable(value_length) && $stable(closed_count)))
		else $error("stalled word changed");

endmodule

bind ber_tlv_stream_parser btlv_chk u_btlv_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.res_valid    (res.valid),
	.res_ready    (res.ready),
	.byte_role    (res.byte_role),
	.depth        (res.depth),
	.tag_value    (res.tag_value),
	.value_length (res.value_length),
	.header_done  (res.header_done),
	.closed_count (res.closed_count),
	.error_code   (res.error_code)
);

### tb/tlv_report_checker.sv
// ----------------------------------------------------------------------------
// tlv_report_checker: report word predictor and scoreboard
// Watches the byte channel and the report channel of the BER-TLV parser. Each
// accepted byte runs through a behavioral copy of the parser state to give the
// expected report word. Each accepted report word is compared field by field
// with the oldest expected one. Failures are counted for the testbench top.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tlv_report_checker (
	input  logic clk,
	input  logic arst_n,
	btlv_in_if   msg,
	btlv_out_if  res,
	output int   fail_count,
	output int   words_pending
);
	import btlv_pkg::*;

	typedef enum logic [1:0] {
		SEEK_TAG,
		TAG_CONT,
		IN_LENGTH,
		IN_VALUE
	} parse_phase_t;

	parse_phase_t ph;
	logic [31:0]  tag_acc;
	logic [31:0]  len_acc;
	logic [31:0]  value_left;
	int           tag_cnt;
	int           len_left;
	int           nest;
	logic         cons;
	err_t         sticky;
	logic [31:0]  remain [MAX_DEPTH];

	out_word_t report_q [$];
	out_word_t want;
	int        mismatches = 0;

	assign fail_count = mismatches;

	function automatic out_word_t predict_report(input logic [7:0] b, input logic last);
		out_word_t   w;
		int          d;
		int          i;
		int          closed;
		logic        hdr;
		logic [31:0] parent_left;
		err_t        err;
		d = nest;
		closed = 0;
		hdr = 1'b0;
		err = ERR_NONE;
		parent_left = '0;
		w.byte_role = ROLE_IGNORED;
		if (sticky != ERR_NONE) begin
			w.depth = 4'(nest);
			w.tag_value = tag_acc;
			w.is_constructed = cons;
			w.value_length = len_acc;
			w.header_done = 1'b0;
			w.closed_count = '0;
			w.error_code = sticky;
			return w;
		end
		for (i = 0; i < d; i++)
			remain[i] = remain[i] - 1;
		if (d > 0)
			parent_left = remain[d-1];

		case (ph)
			SEEK_TAG: begin
				w.byte_role = ROLE_TAG;
				cons = |(b & CONSTRUCTED_MASK);
				tag_acc = {24'b0, b};
				tag_cnt = 1;
				len_acc = '0;
				len_left = 0;
				ph = ((b & TAG_LOW_MASK) == TAG_LOW_MASK) ? TAG_CONT : IN_LENGTH;
			end
			TAG_CONT: begin
				w.byte_role = ROLE_TAG;
				tag_acc = {tag_acc[23:0], b};
				tag_cnt++;
				if (|(b & MORE_MASK)) begin
					if (tag_cnt >= MAX_TAG_BYTES)
						err = ERR_TAG_LONG;
				end else begin
					ph = IN_LENGTH;
				end
			end
			IN_LENGTH: begin
				w.byte_role = ROLE_LENGTH;
				if (len_left == 0) begin
					if (!(|(b & MORE_MASK))) begin
						len_acc = {24'b0, b};
						hdr = 1'b1;
					end else if (b == LEN_INDEFINITE || int'(b[6:0]) > MAX_LENGTH_BYTES) begin
						err = ERR_LEN_FORM;
					end else begin
						len_left = int'(b[6:0]);
						len_acc = '0;
					end
				end else if (len_acc[31:24] != 8'd0) begin
					err = ERR_LEN_FORM;
				end else begin
					len_acc = {len_acc[23:0], b};
					len_left--;
					if (len_left == 0)
						hdr = 1'b1;
				end
			end
			default: begin
				w.byte_role = ROLE_VALUE;
				value_left = value_left - 1;
				if (value_left == 0) begin
					closed = 1;
					ph = SEEK_TAG;
				end
			end
		endcase

		if (err == ERR_NONE && hdr) begin
			if (d > 0 && len_acc > parent_left) begin
				err = ERR_OVERRUN;
			end else if (len_acc == 0) begin
				closed = 1;
				ph = SEEK_TAG;
			end else if (cons && d < MAX_DEPTH) begin
				remain[d] = len_acc;
				nest = d + 1;
				ph = SEEK_TAG;
			end else begin
				value_left = len_acc;
				ph = IN_VALUE;
			end
		end else if (err == ERR_NONE && w.byte_role != ROLE_VALUE && d > 0 && parent_left == 0) begin
			err = ERR_OVERRUN;
		end

		// enclosing elements that are now used up close with this word
		if (err == ERR_NONE && ph == SEEK_TAG) begin
			while (nest > 0 && remain[nest-1] == 0) begin
				nest--;
				closed++;
			end
		end

		if (err == ERR_NONE && last && !(ph == SEEK_TAG && nest == 0))
			err = ERR_TRUNCATED;

		if (err != ERR_NONE) begin
			sticky = err;
			hdr = 1'b0;
			closed = 0;
		end

		w.depth = 4'(d);
		w.tag_value = tag_acc;
		w.is_constructed = cons;
		w.value_length = len_acc;
		w.header_done = hdr;
		w.closed_count = 4'(closed);
		w.error_code = err;
		return w;
	endfunction

	function automatic void check_field(input string name, input logic [31:0] e,
		input logic [31:0] a);
		if (e !== a) begin
			mismatches++;
			$display("%0t: %s expected %0h got %0h", $time, name, e, a);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph = SEEK_TAG;
			tag_acc = '0;
			len_acc = '0;
			value_left = '0;
			tag_cnt = 0;
			len_left = 0;
			nest = 0;
			cons = 1'b0;
			sticky = ERR_NONE;
		end else begin
			if (msg.valid && msg.ready)
				report_q.push_back(predict_report(msg.data_byte, msg.last_byte));
			if (res.valid && res.ready) begin
				if (report_q.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected word, expected none got role %0d tag %0h",
						$time, res.byte_role, res.tag_value);
				end else begin
					want = report_q.pop_front();
					check_field("byte_role", want.byte_role, res.byte_role);
					check_field("depth", want.depth, res.depth);
					check_field("tag_value", want.tag_value, res.tag_value);
					check_field("is_constructed", want.is_constructed, res.is_constructed);
					check_field("value_length", want.value_length, res.value_length);
					check_field("header_done", want.header_done, res.header_done);
					check_field("closed_count", want.closed_count, res.closed_count);
					check_field("error_code", want.error_code, res.error_code);
				end
			end
		end
		words_pending = report_q.size();
	end

endmodule

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench top of the BER-TLV stream parser
// Feeds well-formed TLV messages of random shape (multi-byte tags, short and
// long lengths, empty values, nesting down to the deepest level) under varying
// sender gaps and receiver stalls, then one malformed sequence of random kind
// and some bytes after it. The checker module predicts and compares reports.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
	import btlv_pkg::*;

	typedef logic [7:0] byte_q_t [$];

	logic clk;
	logic arst_n = 1'b0;
	int   idle_pct = 0;
	int   stall_pct = 0;
	int   sent = 0;
	int   fails;
	int   pending;

	btlv_in_if  msg_ch ();
	btlv_out_if res_ch ();

	ber_tlv_stream_parser DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.msg    (msg_ch),
		.res    (res_ch)
	);

	tlv_report_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.msg           (msg_ch),
		.res           (res_ch),
		.fail_count    (fails),
		.words_pending (pending)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	always @(posedge clk)
		res_ch.ready <= ($urandom_range(0, 99) >= stall_pct);

	// one TLV element at nesting level lvl; deep forces a chain down to max depth
	function automatic byte_q_t build_element(input int lvl, input int budget, input bit deep);
		byte_q_t    hdr;
		byte_q_t    body;
		byte_q_t    kid;
		logic [7:0] first;
		bit         cons;
		int         len;
		int         nlen;
		int         i;
		cons = deep || (budget > 4 && $urandom_range(0, 1) == 1);
		if (cons && lvl < MAX_DEPTH) begin
			if (deep) begin
				body = build_element(lvl + 1, 0, 1'b1);
			end else begin
				repeat ($urandom_range(0, 3)) begin
					kid = build_element(lvl + 1, $urandom_range(0, budget / 2), 1'b0);
					body = {body, kid};
				end
			end
		end else begin
			repeat ($urandom_range(0, deep ? 3 : (budget > 12 ? 12 : budget)))
				body.push_back(8'($urandom));
		end

		first = 8'($urandom);
		first = cons ? (first | CONSTRUCTED_MASK) : (first & ~CONSTRUCTED_MASK);
		if ($urandom_range(0, 3) == 0) begin
			hdr.push_back(first | TAG_LOW_MASK);
			repeat ($urandom_range(0, MAX_TAG_BYTES - 2))
				hdr.push_back(8'($urandom) | MORE_MASK);
			hdr.push_back(8'($urandom) & ~MORE_MASK);
		end else begin
			if ((first & TAG_LOW_MASK) == TAG_LOW_MASK)
				first = first ^ 8'h01;
			hdr.push_back(first);
		end

		len = body.size();
		if (len < 128 && $urandom_range(0, 3) != 0) begin
			hdr.push_back(8'(len));
		end else begin
			nlen = (len > 255) ? 2 : 1;
			nlen = nlen + $urandom_range(0, MAX_LENGTH_BYTES - nlen);
			hdr.push_back(MORE_MASK | 8'(nlen));
			for (i = nlen - 1; i >= 0; i--)
				hdr.push_back(8'(len >> (8 * i)));
		end
		hdr = {hdr, body};
		return hdr;
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic last);
		while ($urandom_range(0, 99) < idle_pct) begin
			msg_ch.valid <= 1'b0;
			@(posedge clk);
		end
		msg_ch.valid <= 1'b1;
		msg_ch.data_byte <= b;
		msg_ch.last_byte <= last;
		@(posedge clk);
		while (!msg_ch.ready)
			@(posedge clk);
		sent++;
		case ((sent / 200) % 4)
			0: begin
				idle_pct = 0;
				stall_pct = 0;
			end
			1: begin
				idle_pct = 69;
				stall_pct = 0;
			end
			2: begin
				idle_pct = 0;
				stall_pct = 69;
			end
			default: begin
				idle_pct = 33;
				stall_pct = 33;
			end
		endcase
	endtask

	task automatic send_msg(input byte_q_t q, input bit with_last);
		int i;
		for (i = 0; i < q.size(); i++)
			send_byte(q[i], with_last && i == q.size() - 1);
	endtask

	initial begin
		byte_q_t    q;
		byte_q_t    elem;
		byte_q_t    tail;
		err_t       kind;
		logic [7:0] first;
		int         last_at;
		int         lvl;
		int         i;
		msg_ch.valid = 1'b0;
		msg_ch.data_byte = '0;
		msg_ch.last_byte = 1'b0;
		res_ch.ready = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// nesting to max depth; innermost constructed reads as primitive, all close at once
		q = '{CONSTRUCTED_MASK | 8'h01, 8'h01, 8'($urandom)};
		for (lvl = MAX_DEPTH - 1; lvl >= 0; lvl--) begin
			q.push_front(8'(q.size()));
			q.push_front(CONSTRUCTED_MASK | 8'(lvl));
		end
		send_msg(q, 1'b1);

		// longest tag, long length form of zero
		q = '{8'hFF, 8'hFF, 8'hFF, 8'h7F, MORE_MASK | 8'(MAX_LENGTH_BYTES),
			8'h00, 8'h00, 8'h00, 8'h00};
		send_msg(q, 1'b1);

		while (sent < 1750) begin
			q.delete();
			repeat ($urandom_range(1, 3)) begin
				elem = build_element(0, $urandom_range(0, 48), $urandom_range(0, 19) == 0);
				q = {q, elem};
			end
			send_msg(q, $urandom_range(0, 4) != 0);
		end

		// error is sticky and reset comes only once: one malformed sequence ends the run
		kind = err_t'($urandom_range(ERR_TAG_LONG, ERR_TRUNCATED));
		first = {3'($urandom), 5'($urandom_range(0, 30))};
		last_at = -1;
		case (kind)
			ERR_TAG_LONG: begin
				tail.push_back(8'($urandom) | TAG_LOW_MASK);
				repeat (MAX_TAG_BYTES - 1)
					tail.push_back(8'($urandom) | MORE_MASK);
			end
			ERR_LEN_FORM: begin
				tail.push_back(first);
				if ($urandom_range(0, 1))
					tail.push_back(LEN_INDEFINITE);
				else
					tail.push_back(8'($urandom_range(MORE_MASK + MAX_LENGTH_BYTES + 1, 255)));
			end
			ERR_OVERRUN: begin
				tail.push_back(first | CONSTRUCTED_MASK);
				if ($urandom_range(0, 1)) begin
					// parent ends inside the child header
					tail.push_back(8'h01);
					tail.push_back(first);
				end else begin
					// child length exceeds what is left of the parent
					tail.push_back(8'(2 + MAX_LENGTH_BYTES));
					tail.push_back(first);
					tail.push_back(MORE_MASK | 8'(MAX_LENGTH_BYTES));
					tail.push_back(8'($urandom_range(1, 255)));
					repeat (MAX_LENGTH_BYTES - 1)
						tail.push_back(8'($urandom));
				end
			end
			default: begin
				tail.push_back(first & ~CONSTRUCTED_MASK);
				tail.push_back(MORE_MASK | 8'(MAX_LENGTH_BYTES));
				tail.push_back(8'($urandom_range(1, 255)));
				repeat (MAX_LENGTH_BYTES - 1)
					tail.push_back(8'($urandom));
				last_at = $urandom_range(0, tail.size() + 1);
				repeat (2)
					tail.push_back(8'($urandom));
			end
		endcase
		for (i = 0; i < tail.size(); i++)
			send_byte(tail[i], i == last_at);
		repeat (16)
			send_byte(8'($urandom), 1'($urandom));
		msg_ch.valid <= 1'b0;

		do
			@(posedge clk);
		while (pending != 0);
		repeat (8) @(posedge clk);
		if (fails == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("tb failed");
		$finish;
	end

endmodule
